FILE: rtl/bounded_positional_list_defines.svh
// assertion macros shared by the list block
`ifndef BOUNDED_POSITIONAL_LIST_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock while out of reset
`define BPL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a property in the next
`define BPL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define BPL_ASSERT(label, prop, msg)
`define BPL_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

FILE: rtl/blist_pkg.sv
package blist_pkg;

    // default list capacity
    localparam int CAPACITY_DEF = 64;

    // operation codes
    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_BACK   = 3'd3;
    localparam logic [2:0] FN_INSERT_AT  = 3'd4;
    localparam logic [2:0] FN_DELETE_AT  = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // normalized operation kind
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE
    } op_kind_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_FETCH,
        S_REPORT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic step;
        logic place;
        logic commit;
        logic fetch;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        op_kind_t kind;
        logic     busy;
        logic     out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/blist_ctrl.sv
module blist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  blist_pkg::ctrl_sts_t  sts,
    output blist_pkg::ctrl_cmd_t  cmd
);

    blist_pkg::state_t state_reg;
    blist_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blist_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blist_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = blist_pkg::S_SHIFT;
                end
            end
            blist_pkg::S_SHIFT:
            begin
                if (!sts.busy)
                begin
                    if (sts.kind == blist_pkg::OP_INSERT)
                    begin
                        state_next = blist_pkg::S_PLACE;
                    end
                    else
                    begin
                        state_next = blist_pkg::S_FETCH;
                    end
                end
            end
            blist_pkg::S_PLACE:
            begin
                state_next = blist_pkg::S_FETCH;
            end
            blist_pkg::S_FETCH:
            begin
                state_next = blist_pkg::S_REPORT;
            end
            blist_pkg::S_REPORT:
            begin
                if (sts.out_free)
                begin
                    state_next = blist_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = blist_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            blist_pkg::S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            blist_pkg::S_SHIFT:
            begin
                cmd.step   = 1'b1;
                cmd.commit = !sts.busy && (sts.kind != blist_pkg::OP_INSERT);
            end
            blist_pkg::S_PLACE:
            begin
                cmd.place  = 1'b1;
                cmd.commit = 1'b1;
            end
            blist_pkg::S_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            blist_pkg::S_REPORT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/blist_dp.sv
`include "bounded_positional_list_defines.svh"

module blist_dp #(
    parameter int CAPACITY = blist_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  blist_pkg::ctrl_cmd_t  cmd,
    output blist_pkg::ctrl_sts_t  sts,
    input  logic [2:0]            func,
    input  logic signed [31:0]    value,
    input  logic [7:0]            position,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [CW-1:0]         count,
    output logic signed [31:0]    first_value,
    output logic signed [31:0]    last_value
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 8) ? CW : 8;

    // element store
    logic [31:0] store_mem [CAPACITY];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;

    // list length
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // operation held for the item in progress
    blist_pkg::op_kind_t kind_reg;
    logic [AW-1:0]       ix_reg;
    logic signed [31:0]  val_reg;
    logic [1:0]          stat_reg;

    // shift walk
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [AW-1:0] src_reg;
    logic [AW-1:0] src_next;
    logic          up_reg;
    logic          pipe_v_reg;
    logic          pipe_v_next;
    logic [AW-1:0] pipe_dst_reg;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          out_stat_reg;
    logic [CW-1:0]       out_count_reg;
    logic signed [31:0]  out_first_reg;
    logic signed [31:0]  out_last_reg;

    // decode of the incoming item
    blist_pkg::op_kind_t dec_kind;
    logic [AW-1:0]       dec_ix;
    logic [1:0]          dec_stat;
    logic [CMPW-1:0]     pos_ext;
    logic [CMPW-1:0]     cnt_ext;
    logic [CW-1:0]       cnt_m1;
    logic                is_full;
    logic                is_empty;
    logic                out_taken;

    assign pos_ext  = CMPW'(position);
    assign cnt_ext  = CMPW'(count_reg);
    assign cnt_m1   = count_reg - CW'(1);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // map each function onto insert or delete at an index, or onto a status when it is refused
    always_comb
    begin
        dec_kind = blist_pkg::OP_NONE;
        dec_ix   = '0;
        dec_stat = blist_pkg::STAT_DONE;
        unique case (func)
            blist_pkg::FN_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    dec_stat = blist_pkg::STAT_FULL;
                end
                else
                begin
                    dec_kind = blist_pkg::OP_INSERT;
                end
            end
            blist_pkg::FN_PUSH_BACK:
            begin
                if (is_full)
                begin
                    dec_stat = blist_pkg::STAT_FULL;
                end
                else
                begin
                    dec_kind = blist_pkg::OP_INSERT;
                    dec_ix   = count_reg[AW-1:0];
                end
            end
            blist_pkg::FN_POP_FRONT:
            begin
                if (is_empty)
                begin
                    dec_stat = blist_pkg::STAT_IGNORED;
                end
                else
                begin
                    dec_kind = blist_pkg::OP_DELETE;
                end
            end
            blist_pkg::FN_POP_BACK:
            begin
                if (is_empty)
                begin
                    dec_stat = blist_pkg::STAT_IGNORED;
                end
                else
                begin
                    dec_kind = blist_pkg::OP_DELETE;
                    dec_ix   = cnt_m1[AW-1:0];
                end
            end
            blist_pkg::FN_INSERT_AT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    dec_stat = blist_pkg::STAT_IGNORED;
                end
                else if (is_full)
                begin
                    dec_stat = blist_pkg::STAT_FULL;
                end
                else
                begin
                    dec_kind = blist_pkg::OP_INSERT;
                    dec_ix   = pos_ext[AW-1:0];
                end
            end
            blist_pkg::FN_DELETE_AT:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    dec_stat = blist_pkg::STAT_IGNORED;
                end
                else
                begin
                    dec_kind = blist_pkg::OP_DELETE;
                    dec_ix   = pos_ext[AW-1:0];
                end
            end
            default:
            begin
                dec_stat = blist_pkg::STAT_IGNORED;
            end
        endcase
    end

    // walk counters: one entry read per step, written one step later
    always_comb
    begin
        rem_next    = rem_reg;
        src_next    = src_reg;
        pipe_v_next = pipe_v_reg;
        if (cmd.start)
        begin
            pipe_v_next = 1'b0;
            unique case (dec_kind)
                blist_pkg::OP_INSERT:
                begin
                    rem_next = count_reg - CW'(dec_ix);
                    src_next = cnt_m1[AW-1:0];
                end
                blist_pkg::OP_DELETE:
                begin
                    rem_next = cnt_m1 - CW'(dec_ix);
                    src_next = dec_ix + AW'(1);
                end
                default:
                begin
                    rem_next = '0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            pipe_v_next = (rem_reg != '0);
            if (rem_reg != '0)
            begin
                rem_next = rem_reg - CW'(1);
                src_next = up_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
            end
        end
    end

    // walk control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            pipe_v_reg <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            pipe_v_reg <= pipe_v_next;
        end
    end

    // walk and item payload registers
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        if (cmd.start)
        begin
            kind_reg <= dec_kind;
            ix_reg   <= dec_ix;
            val_reg  <= value;
            stat_reg <= dec_stat;
            up_reg   <= (dec_kind == blist_pkg::OP_INSERT);
        end
        if (cmd.step && (rem_reg != '0))
        begin
            pipe_dst_reg <= up_reg ? (src_reg + AW'(1)) : (src_reg - AW'(1));
        end
    end

    // store write and read ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pipe_dst_reg;
        mem_wdata = rd_a_reg;
        if (cmd.place)
        begin
            mem_we    = 1'b1;
            mem_waddr = ix_reg;
            mem_wdata = val_reg;
        end
        else if (cmd.step && pipe_v_reg)
        begin
            mem_we = 1'b1;
        end
    end

    assign rd_a_addr = cmd.fetch ? '0 : src_reg;
    assign rd_b_addr = cnt_m1[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        // head value kept after the fetch while the result waits
        if (cmd.step || cmd.fetch)
        begin
            rd_a_reg <= store_mem[rd_a_addr];
        end
        rd_b_reg <= store_mem[rd_b_addr];
    end

    // length update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            unique case (kind_reg)
                blist_pkg::OP_INSERT: count_next = count_reg + CW'(1);
                blist_pkg::OP_DELETE: count_next = cnt_m1;
                default:              count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result register, freed by an output transfer
    assign out_taken = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_stat_reg  <= stat_reg;
            out_count_reg <= count_reg;
            out_first_reg <= is_empty ? '0 : $signed(rd_a_reg);
            out_last_reg  <= is_empty ? '0 : $signed(rd_b_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign count       = out_count_reg;
    assign first_value = out_first_reg;
    assign last_value  = out_last_reg;

    // status back to the controller
    assign sts.kind     = kind_reg;
    assign sts.busy     = (rem_reg != '0) || pipe_v_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    // checks
    `BPL_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "list length above capacity")
    `BPL_ASSERT_NEXT(a_count_hold, !cmd.commit, count_reg == $past(count_reg), "length moved without commit")
    `BPL_ASSERT(a_place_after_walk, cmd.place |-> !pipe_v_reg && (rem_reg == '0), "value placed mid walk")
    `BPL_ASSERT(a_fetch_no_write, cmd.fetch |-> !mem_we, "store written during head and tail fetch")
    `BPL_ASSERT(a_load_when_free, cmd.load_out |-> !out_valid_reg || !out_stall, "result overwritten")

endmodule

FILE: rtl/bounded_positional_list.sv
// sequence: the walk moves m entries, m = 0 .. CAPACITY-1; an insert then places its value,
// then the head and tail are fetched and the result is loaded
// throughput: one item at a time; the next transfer is taken the cycle after the
// result is loaded, set by the single write port of the store moving one entry a cycle
// reset: length cleared to zero and no result pending; store contents left as they are
module bounded_positional_list #(
    parameter int CAPACITY = blist_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          func,
    input  logic signed [31:0]  value,
    input  logic [7:0]          position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [CW-1:0]       count,
    output logic signed [31:0]  first_value,
    output logic signed [31:0]  last_value
);

    blist_pkg::ctrl_cmd_t cmd;
    blist_pkg::ctrl_sts_t sts;

    // sequencer
    blist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, walk and result registers
    blist_dp #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .count       (count),
        .first_value (first_value),
        .last_value  (last_value)
    );

endmodule
